@@ rtl/bpolc_pkg.sv @@
// Shared types and constants for the beam pair occupancy and lamp controller.
package bpolc_pkg;

  // Width of the internal people counter
  localparam int unsigned COUNT_W = 16;
  // Fixed field widths
  localparam int unsigned OCC_W   = 16;
  localparam int unsigned LIGHT_W = 7;
  localparam int unsigned TMR_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Register reset values
  localparam logic [TMR_W-1:0]   TIMEOUT_RST   = TMR_W'(200);
  localparam logic [LIGHT_W-1:0] THRESHOLD_RST = LIGHT_W'(50);

  typedef logic [COUNT_W-1:0] count_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT   = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  // Direction machine states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ENTER = 2'd1,
    ST_LEAVE = 2'd2,
    ST_DONE  = 2'd3
  } dir_state_t;

  // One result item
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic             lamp_on;
  } result_t;

endpackage

@@ rtl/beam_pair_occupancy_light_control.sv @@
// Top level of the beam pair occupancy counter with lamp control.
//
//   channel   direction  handshake           payload
//   in_       request    in_valid/in_stall   in_outer_beam, in_inner_beam, in_light_level
//   out_      result     out_valid/out_stall out_occupancy, out_lamp_on
//   cfg_      write      cfg_we              cfg_index, cfg_wdata
//
// One request per cycle is accepted while in_stall is low; its result is registered.
// The direction machine, timer and counter update together on each accepted request.
// A one-entry skid still accepts a request after out_stall rises on a valid result.
// Reset (rst_n low, synchronous) idles the machine, clears the count and
// restores timeout 200 and threshold 50.
module beam_pair_occupancy_light_control (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_outer_beam,
  input  logic                            in_inner_beam,
  input  logic [bpolc_pkg::LIGHT_W-1:0]   in_light_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpolc_pkg::OCC_W-1:0]     out_occupancy,
  output logic                            out_lamp_on,
  input  logic                            cfg_we,
  input  logic [bpolc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpolc_pkg::CFG_W-1:0]     cfg_wdata
);
  import bpolc_pkg::*;

  logic [TMR_W-1:0]   timeout_r, timeout_nxt;
  logic [LIGHT_W-1:0] threshold_r, threshold_nxt;
  logic               accept;
  result_t            fsm_result;
  result_t            out_data;

  assign accept = in_valid && !in_stall;

  // Decode configuration writes
  always_comb begin
    timeout_nxt   = timeout_r;
    threshold_nxt = threshold_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT:   timeout_nxt   = cfg_wdata[TMR_W-1:0];
        REG_THRESHOLD: threshold_nxt = cfg_wdata[LIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      threshold_r <= THRESHOLD_RST;
    end else begin
      timeout_r   <= timeout_nxt;
      threshold_r <= threshold_nxt;
    end
  end

  bpolc_fsm u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .outer_beam     (in_outer_beam),
    .inner_beam     (in_inner_beam),
    .light_level    (in_light_level),
    .timeout_ticks  (timeout_r),
    .lamp_threshold (threshold_r),
    .result         (fsm_result)
  );

  bpolc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (fsm_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_occupancy = out_data.occupancy;
  assign out_lamp_on   = out_data.lamp_on;

endmodule

@@ rtl/bpolc_fsm.sv @@
// Direction machine, crossing timer and people counter with lamp decision.
module bpolc_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          outer_beam,
  input  logic                          inner_beam,
  input  logic [bpolc_pkg::LIGHT_W-1:0] light_level,
  input  logic [bpolc_pkg::TMR_W-1:0]   timeout_ticks,
  input  logic [bpolc_pkg::LIGHT_W-1:0] lamp_threshold,
  output bpolc_pkg::result_t            result
);
  import bpolc_pkg::*;

  dir_state_t          state_r, state_nxt;
  logic [TMR_W-1:0]    timer_r, timer_nxt;
  count_t              count_r, count_nxt;

  logic                outer_blk;
  logic                inner_blk;
  dir_state_t          state_mid;
  logic [TMR_W-1:0]    timer_mid;

  assign outer_blk = ~outer_beam;
  assign inner_blk = ~inner_beam;

  // Advance the machine by one tick
  always_comb begin
    state_mid = state_r;
    timer_mid = timer_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (outer_blk) begin
          state_mid = ST_ENTER;
          timer_mid = timeout_ticks;
        end else if (inner_blk) begin
          state_mid = ST_LEAVE;
          timer_mid = timeout_ticks;
        end
      end
      ST_ENTER: begin
        if (inner_blk) begin
          if (count_r != '1) begin
            count_nxt = count_r + COUNT_W'(1);
          end
          state_mid = ST_DONE;
        end
      end
      ST_LEAVE: begin
        if (outer_blk) begin
          if (count_r != '0) begin
            count_nxt = count_r - COUNT_W'(1);
          end
          state_mid = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!outer_blk && !inner_blk) begin
          state_mid = ST_IDLE;
        end
      end
      default: state_mid = ST_IDLE;
    endcase

    // Count down the crossing timer, drop to idle when it runs out
    state_nxt = state_mid;
    timer_nxt = timer_mid;
    if (state_mid != ST_IDLE) begin
      if (timer_mid != '0) begin
        timer_nxt = timer_mid - TMR_W'(1);
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // Build the result from the updated count
  always_comb begin
    result.occupancy = OCC_W'(count_nxt);
    result.lamp_on   = (count_nxt != '0) && (light_level < lamp_threshold);
  end

  // Hold state until a request is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timer_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/bpolc_outbuf.sv @@
// Output register with one skid entry between the result side and the request side.
module bpolc_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpolc_pkg::result_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpolc_pkg::result_t out_data
);
  import bpolc_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    accept;
  logic    out_fire;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Route new results to the output register or skid entry; the skid drains first
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_fire) begin
        out_data_nxt  = in_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = in_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

@@ rtl/bpolc_checker.sv @@
// Port-level checks for the occupancy controller, bound to the top level.
module bpolc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_outer_beam,
  input logic                            in_inner_beam,
  input logic [bpolc_pkg::LIGHT_W-1:0]   in_light_level,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bpolc_pkg::OCC_W-1:0]     out_occupancy,
  input logic                            out_lamp_on,
  input logic                            cfg_we,
  input logic [bpolc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [bpolc_pkg::CFG_W-1:0]     cfg_wdata
);
  import bpolc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Fill the skid entry only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("request side stalled without a stalled result");

  // Drain the skid entry once the result side moves
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("skid entry did not drain");

  // Light the lamp only for an occupied room
  a_lamp_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lamp_on |-> out_occupancy != '0)
    else $error("lamp on with zero occupancy");

endmodule

bind beam_pair_occupancy_light_control bpolc_checker u_bpolc_checker (.*);
